// ===== design/ell_pkg.sv =====
// Shared types, command codes and defaults for the event list block.
package ell_pkg;

  // Defaults for the top-level parameters
  localparam int LIST_DEPTH_DEF  = 16;
  localparam int ENTRY_WIDTH_DEF = 32;

  // Pop interval after reset, in ticks
  localparam logic [31:0] POP_INTERVAL_RESET = 32'd5000;

  // Command codes
  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_REMOVE = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_SWAP   = 3'd3;
  localparam logic [2:0] KIND_POP    = 3'd4;
  localparam logic [2:0] KIND_TICK   = 3'd5;

  // Command word
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] payload;
    logic [3:0]  index_a;
    logic [3:0]  index_b;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic        status;
    logic [31:0] payload_out;
    logic [4:0]  entry_count;
    logic        pop_request;
  } out_word_t;

  // Controller to timer
  typedef struct packed {
    logic tick;
    logic nonempty;
  } tick_ctl_t;

endpackage

// ===== design/ell_mem.sv =====
// Entry storage: one write port, one read port, registered read data.
module ell_mem #(
  parameter int DEPTH = ell_pkg::LIST_DEPTH_DEF,
  parameter int WIDTH = ell_pkg::ENTRY_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/ell_timer.sv =====
// Tick counter, pop interval register and pop request decision.
module ell_timer (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  ell_pkg::tick_ctl_t ctl,
  output logic             req
);

  // Ticks since the last pop request, modulo 2^32
  logic [31:0] elapsed;
  logic [31:0] interval;
  logic [31:0] elapsed_next;

  // Decide on the elapsed time as it stands after this tick
  assign elapsed_next = elapsed + 32'd1;
  assign req          = ctl.nonempty && (elapsed_next > interval);

  // Hold the interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= ell_pkg::POP_INTERVAL_RESET;
    end else if (cfg_we) begin
      interval <= cfg_wdata;
    end
  end

  // Advance on a tick, restart on a request
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (ctl.tick) begin
      elapsed <= req ? 32'd0 : elapsed_next;
    end
  end

endmodule

// ===== design/ell_ctrl.sv =====
// Command sequencer: decode, read-modify-write on entry memory, result register.
module ell_ctrl #(
  parameter int LIST_DEPTH  = ell_pkg::LIST_DEPTH_DEF,
  parameter int ENTRY_WIDTH = ell_pkg::ENTRY_WIDTH_DEF,
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
  localparam int CW = $clog2(LIST_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ell_pkg::in_word_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output ell_pkg::out_word_t     out_data,
  output logic                   mem_wr_en,
  output logic [AW-1:0]          mem_wr_addr,
  output logic [ENTRY_WIDTH-1:0] mem_wr_data,
  output logic                   mem_rd_en,
  output logic [AW-1:0]          mem_rd_addr,
  input  logic [ENTRY_WIDTH-1:0] mem_rd_data,
  output ell_pkg::tick_ctl_t     tick_ctl,
  input  logic                   pop_req
);

  localparam int XW = (CW > 4) ? CW : 4;

  typedef enum logic [3:0] {
    IDLE, DECODE, RD_WAIT, SW_A, SW_B, SW_W, RM_CAP, SH_CHK, SH_WR, RESP
  } state_t;

  state_t              state;
  ell_pkg::in_word_t   cmd;
  logic [CW-1:0]       count;
  logic [AW-1:0]       ptr;
  logic [ENTRY_WIDTH-1:0] tmp;
  logic                res_status;
  logic [ENTRY_WIDTH-1:0] res_word;
  logic                res_req;

  logic ia_ok, ib_ok, not_full, nonempty, shift_more;
  logic [AW-1:0] addr_a, addr_b, ptr_inc;

  // Range checks against the held entries
  assign ia_ok      = XW'(cmd.index_a) < XW'(count);
  assign ib_ok      = XW'(cmd.index_b) < XW'(count);
  assign not_full   = count != CW'(LIST_DEPTH);
  assign nonempty   = count != '0;
  assign addr_a     = AW'(cmd.index_a);
  assign addr_b     = AW'(cmd.index_b);
  assign ptr_inc    = AW'(ptr + AW'(1));
  assign shift_more = (CW'(ptr) + CW'(1)) < count;

  assign in_ready          = state == IDLE;
  assign tick_ctl.nonempty = nonempty;
  assign tick_ctl.tick     = (state == DECODE) && (cmd.kind == ell_pkg::KIND_TICK);

  // Drive memory ports from the current step
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = mem_rd_data;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    unique case (state)
      DECODE: begin
        unique case (cmd.kind)
          ell_pkg::KIND_APPEND: begin
            mem_wr_en   = not_full;
            mem_wr_addr = AW'(count);
            mem_wr_data = ENTRY_WIDTH'(cmd.payload);
          end
          ell_pkg::KIND_REMOVE, ell_pkg::KIND_READ, ell_pkg::KIND_SWAP: begin
            mem_rd_en   = ia_ok;
            mem_rd_addr = addr_a;
          end
          ell_pkg::KIND_POP: begin
            mem_rd_en   = nonempty;
            mem_rd_addr = '0;
          end
          default: begin
            mem_rd_en = 1'b0;
          end
        endcase
      end
      SW_A: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = addr_b;
      end
      SW_B: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_a;
      end
      SW_W: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_b;
        mem_wr_data = tmp;
      end
      SH_CHK: begin
        mem_rd_en   = shift_more;
        mem_rd_addr = ptr_inc;
      end
      SH_WR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  // Sequence the command and hold the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Retire a taken word unless the next one loads in this cycle
      if (out_valid && out_ready && state != RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            cmd   <= in_data;
            state <= DECODE;
          end
        end
        DECODE: begin
          res_status <= 1'b0;
          res_word   <= '0;
          res_req    <= 1'b0;
          state      <= RESP;
          unique case (cmd.kind)
            ell_pkg::KIND_APPEND: begin
              if (not_full) begin
                count <= count + CW'(1);
              end else begin
                res_status <= 1'b1;
              end
            end
            ell_pkg::KIND_REMOVE: begin
              if (ia_ok) begin
                ptr   <= addr_a;
                state <= RM_CAP;
              end else begin
                res_status <= 1'b1;
              end
            end
            ell_pkg::KIND_READ: begin
              if (ia_ok) begin
                state <= RD_WAIT;
              end else begin
                res_status <= 1'b1;
              end
            end
            ell_pkg::KIND_SWAP: begin
              if (ia_ok && ib_ok) begin
                state <= SW_A;
              end else begin
                res_status <= 1'b1;
              end
            end
            ell_pkg::KIND_POP: begin
              if (nonempty) begin
                ptr   <= '0;
                state <= RM_CAP;
              end else begin
                res_status <= 1'b1;
              end
            end
            ell_pkg::KIND_TICK: begin
              res_req <= pop_req;
            end
            default: begin
              res_status <= 1'b1;
            end
          endcase
        end
        RD_WAIT: begin
          res_word <= mem_rd_data;
          state    <= RESP;
        end
        SW_A: begin
          tmp   <= mem_rd_data;
          state <= SW_B;
        end
        SW_B: begin
          state <= SW_W;
        end
        SW_W: begin
          state <= RESP;
        end
        RM_CAP: begin
          if (cmd.kind == ell_pkg::KIND_POP) begin
            res_word <= mem_rd_data;
          end
          state <= SH_CHK;
        end
        SH_CHK: begin
          if (shift_more) begin
            state <= SH_WR;
          end else begin
            count <= count - CW'(1);
            state <= RESP;
          end
        end
        SH_WR: begin
          ptr   <= ptr_inc;
          state <= SH_CHK;
        end
        RESP: begin
          if (!out_valid || out_ready) begin
            out_data.status      <= res_status;
            out_data.payload_out <= 32'(res_word);
            out_data.entry_count <= 5'(count);
            out_data.pop_request <= res_req;
            out_valid            <= 1'b1;
            state                <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(LIST_DEPTH))
    else $error("entry count beyond depth");

  // A shift write stays inside the held entries
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    state == SH_WR |-> (CW'(ptr) + CW'(1)) < count)
    else $error("shift beyond held entries");

  // Count changes only on append or at the end of a shift
  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !(state == DECODE || state == SH_CHK) |=> $stable(count))
    else $error("count changed outside append or remove");

  // A raised pop request is never a refused word
  a_req_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pop_request |-> !out_data.status)
    else $error("pop request on a refused word");

endmodule

// ===== design/event_list_with_timed_pop_top.sv =====
// Top level of the event list with timed pop request.
//
//  port group      dir  handshake              word
//  in_*            in   in_valid / in_ready    ell_pkg::in_word_t
//  out_*           out  out_valid / out_ready  ell_pkg::out_word_t
//  cfg_*           in   cfg_we, no wait        cfg_wdata, pop interval
//
// One command at a time, taken only when the sequencer is idle. Append,
// tick and refused commands go from DECODE to RESP, read through RD_WAIT;
// swap through SW_A, SW_B and SW_W. Remove and pop shift the later entries up
// through the single memory read port, one entry per SH_CHK / SH_WR pass.
// Reset (synchronous) empties the list, zeroes elapsed time and loads the
// interval 5000; entry memory is not cleared. A stalled result holds in the
// output register while the next command is already accepted.
module event_list_with_timed_pop_top #(
  parameter int LIST_DEPTH  = ell_pkg::LIST_DEPTH_DEF,
  parameter int ENTRY_WIDTH = ell_pkg::ENTRY_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ell_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ell_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [ENTRY_WIDTH-1:0] mem_wr_data;
  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [ENTRY_WIDTH-1:0] mem_rd_data;
  ell_pkg::tick_ctl_t     tick_ctl;
  logic                   pop_req;

  // Entry storage
  ell_mem #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (ENTRY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Tick counter and interval
  ell_timer u_timer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (tick_ctl),
    .req       (pop_req)
  );

  // Command sequencer
  ell_ctrl #(
    .LIST_DEPTH  (LIST_DEPTH),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .tick_ctl    (tick_ctl),
    .pop_req     (pop_req)
  );

endmodule

// ===== verif/tb_event_list_with_timed_pop_top.sv =====
// Testbench for the event list with timed pop: directed and random commands against a predictor.
module tb_event_list_with_timed_pop_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DEPTH          = ell_pkg::LIST_DEPTH_DEF;
  localparam logic [2:0]  KIND_SPARE_LO  = 3'd6;
  localparam logic [2:0]  KIND_SPARE_HI  = 3'd7;
  localparam logic [31:0] WORD_ONES      = 32'hFFFF_FFFF;
  localparam int          SETTLE_CYCLES  = 60;
  localparam int          CYCLE_LIMIT    = 2_000_000;
  localparam int          MAX_REPORTS    = 10;
  localparam int          PHASE_ITEMS    = 130;
  localparam int          MIX_STRETCH    = 35;
  localparam int          RESET_TICKS    = 40;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN, MIX_TICKS} mix_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  ell_pkg::in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ell_pkg::out_word_t out_data;
  logic      cfg_we;
  logic [31:0] cfg_wdata;

  // Shadow of the list, the timer and the interval register
  logic [31:0] list_mem [DEPTH];
  logic [4:0]  list_len;
  logic [31:0] tick_count;
  logic [31:0] last_request_tick;
  logic [31:0] pop_gap_cfg;

  ell_pkg::out_word_t pending_results [$];
  int          mismatch_count;
  int          cycle_count;
  int          burst_left;
  bit          quiet_sender;

  event_list_with_timed_pop_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Close the gap left at pos by moving later entries up
  function automatic void close_gap(input logic [4:0] pos);
    for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len = list_len - 5'd1;
  endfunction

  // Apply one command to the shadow list and return the result it should give
  function automatic ell_pkg::out_word_t predict_list_op(input ell_pkg::in_word_t w);
    ell_pkg::out_word_t r;
    logic [31:0] held;
    logic [31:0] elapsed;
    r = '0;
    case (w.kind)
      ell_pkg::KIND_APPEND: begin
        if (list_len >= DEPTH) begin
          r.status = 1'b1;
        end else begin
          list_mem[4'(list_len)] = w.payload;
          list_len = list_len + 5'd1;
        end
      end
      ell_pkg::KIND_REMOVE: begin
        if (w.index_a >= list_len) r.status = 1'b1;
        else close_gap(w.index_a);
      end
      ell_pkg::KIND_READ: begin
        if (w.index_a >= list_len) r.status = 1'b1;
        else r.payload_out = list_mem[w.index_a];
      end
      ell_pkg::KIND_SWAP: begin
        if (w.index_a >= list_len || w.index_b >= list_len) begin
          r.status = 1'b1;
        end else begin
          held = list_mem[w.index_a];
          list_mem[w.index_a] = list_mem[w.index_b];
          list_mem[w.index_b] = held;
        end
      end
      ell_pkg::KIND_POP: begin
        if (list_len == 0) begin
          r.status = 1'b1;
        end else begin
          r.payload_out = list_mem[0];
          close_gap(5'd0);
        end
      end
      ell_pkg::KIND_TICK: begin
        tick_count = tick_count + 32'd1;
        elapsed = tick_count - last_request_tick;
        if (list_len != 0 && elapsed > pop_gap_cfg) begin
          r.pop_request = 1'b1;
          last_request_tick = tick_count;
        end
      end
      default: r.status = 1'b1;
    endcase
    r.entry_count = list_len;
    return r;
  endfunction

  function automatic ell_pkg::in_word_t make_cmd(input logic [2:0] kind,
                                                 input logic [31:0] payload,
                                                 input logic [3:0] ia, input logic [3:0] ib);
    ell_pkg::in_word_t w;
    w.kind = kind;
    w.payload = payload;
    w.index_a = ia;
    w.index_b = ib;
    return w;
  endfunction

  // Mostly a live position, sometimes any position
  function automatic logic [3:0] pick_index();
    if ($urandom_range(0, 99) < 80 && list_len != 0) return 4'($urandom_range(0, list_len - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic ell_pkg::in_word_t make_random_cmd(input mix_t mix);
    int          w_app, w_rem, w_rd, w_sw, w_pop, w_tick;
    int          pick;
    logic [2:0]  kind;
    logic [31:0] payload;
    case (mix)
      MIX_FILL:  begin w_app = 60; w_rem = 5;  w_rd = 10; w_sw = 8;  w_pop = 5;  w_tick = 10; end
      MIX_DRAIN: begin w_app = 12; w_rem = 25; w_rd = 10; w_sw = 8;  w_pop = 30; w_tick = 10; end
      MIX_TICKS: begin w_app = 20; w_rem = 5;  w_rd = 10; w_sw = 5;  w_pop = 8;  w_tick = 48; end
      default:   begin w_app = 25; w_rem = 10; w_rd = 15; w_sw = 12; w_pop = 10; w_tick = 23; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < w_app) kind = ell_pkg::KIND_APPEND;
    else if (pick < w_app + w_rem) kind = ell_pkg::KIND_REMOVE;
    else if (pick < w_app + w_rem + w_rd) kind = ell_pkg::KIND_READ;
    else if (pick < w_app + w_rem + w_rd + w_sw) kind = ell_pkg::KIND_SWAP;
    else if (pick < w_app + w_rem + w_rd + w_sw + w_pop) kind = ell_pkg::KIND_POP;
    else if (pick < w_app + w_rem + w_rd + w_sw + w_pop + w_tick) kind = ell_pkg::KIND_TICK;
    else kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    case ($urandom_range(0, 9))
      0:       payload = '0;
      1:       payload = WORD_ONES;
      default: payload = $urandom;
    endcase
    return make_cmd(kind, payload, pick_index(), pick_index());
  endfunction

  // Sender pacing: bursts of random length with random gaps between them unless the sender is quiet
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = quiet_sender ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Offer one word, hold it until taken, record what it should produce
  task automatic push_command(input ell_pkg::in_word_t w, output ell_pkg::out_word_t predicted);
    if (!in_valid) in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_list_op(w);
    pending_results.push_back(predicted);
    @(negedge clk);
    pace();
  endtask

  task automatic send(input ell_pkg::in_word_t w);
    ell_pkg::out_word_t unused;
    push_command(w, unused);
  endtask

  // Drop valid and wait until every result is back and the block is quiet
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_interval(input logic [31:0] value);
    wait_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    pop_gap_cfg = value;
  endtask

  // Refused commands, field extremes and every operation at the reset interval
  task automatic test_directed_ops();
    quiet_sender = 1'b0;
    send(make_cmd(ell_pkg::KIND_POP, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_REMOVE, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_READ, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_SWAP, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_TICK, '0, 4'd0, 4'd0));
    send(make_cmd(KIND_SPARE_LO, '0, 4'd0, 4'd0));
    send(make_cmd(KIND_SPARE_HI, WORD_ONES, 4'hF, 4'hF));
    send(make_cmd(ell_pkg::KIND_APPEND, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_APPEND, WORD_ONES, 4'hF, 4'hF));
    send(make_cmd(ell_pkg::KIND_APPEND, 32'hA5A5_A5A5, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_APPEND, 32'h5A5A_5A5A, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_READ, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_READ, '0, 4'd3, 4'd0));
    send(make_cmd(ell_pkg::KIND_READ, '0, 4'd4, 4'd0));
    send(make_cmd(ell_pkg::KIND_READ, '0, 4'hF, 4'd0));
    send(make_cmd(ell_pkg::KIND_SWAP, '0, 4'd0, 4'd3));
    send(make_cmd(ell_pkg::KIND_SWAP, '0, 4'd1, 4'd4));
    send(make_cmd(ell_pkg::KIND_SWAP, '0, 4'hF, 4'd0));
    send(make_cmd(ell_pkg::KIND_SWAP, '0, 4'd2, 4'd2));
    send(make_cmd(ell_pkg::KIND_REMOVE, '0, 4'd1, 4'd0));
    send(make_cmd(ell_pkg::KIND_REMOVE, '0, 4'd2, 4'd0));
    send(make_cmd(ell_pkg::KIND_REMOVE, '0, 4'd9, 4'd0));
    send(make_cmd(ell_pkg::KIND_POP, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_POP, '0, 4'd0, 4'd0));
    send(make_cmd(ell_pkg::KIND_POP, '0, 4'd0, 4'd0));
  endtask

  // Tick with a held entry at the reset interval, well short of a pop request
  task automatic test_reset_interval();
    quiet_sender = 1'b1;
    if (list_len == 0) send(make_cmd(ell_pkg::KIND_APPEND, $urandom, 4'd0, 4'd0));
    for (int t = 0; t < RESET_TICKS; t++)
      send(make_cmd(ell_pkg::KIND_TICK, $urandom, 4'($urandom), 4'($urandom)));
    send(make_cmd(ell_pkg::KIND_POP, '0, 4'd0, 4'd0));
  endtask

  // Random traffic over several interval settings, extremes included
  task automatic test_random_traffic();
    logic [31:0] intervals [8];
    intervals[0] = 32'd0;
    intervals[1] = WORD_ONES;
    intervals[2] = 32'd1;
    intervals[3] = 32'($urandom_range(2, 12));
    intervals[4] = 32'd3;
    intervals[5] = 32'($urandom_range(5, 40));
    intervals[6] = 32'd0;
    intervals[7] = 32'($urandom_range(1, 6));
    for (int p = 0; p < 8; p++) begin
      write_interval(intervals[p]);
      quiet_sender = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) send(make_random_cmd(mix_t'((i / MIX_STRETCH + p) % 4)));
    end
  endtask

  // Receiver stalls: stretches of always-ready, random and periodic patterns
  initial begin
    int mode;
    int span;
    int period;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 128);
      period = $urandom_range(2, 6);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (c % period == 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    ell_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: status=%0b word=%h count=%0d req=%0b",
                   out_data.status, out_data.payload_out, out_data.entry_count,
                   out_data.pop_request);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.payload_out !== want.payload_out ||
            out_data.entry_count !== want.entry_count ||
            out_data.pop_request !== want.pop_request) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp st=%0b w=%h n=%0d rq=%0b got st=%0b w=%h n=%0d rq=%0b",
                     want.status, want.payload_out, want.entry_count, want.pop_request,
                     out_data.status, out_data.payload_out, out_data.entry_count,
                     out_data.pop_request);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    list_len = '0;
    tick_count = '0;
    last_request_tick = '0;
    pop_gap_cfg = ell_pkg::POP_INTERVAL_RESET;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    quiet_sender = 1'b0;
    for (int i = 0; i < DEPTH; i++) list_mem[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_ops();
    test_reset_interval();
    test_random_traffic();
    wait_drain();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
